### rtl/olt_pkg.sv
// shared types and codes for the ordered line table
package olt_pkg;

  // command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_RESET  = 3'd2;
  localparam logic [2:0] CMD_FETCH  = 3'd3;
  localparam logic [2:0] CMD_NEXT   = 3'd4;
  localparam logic [2:0] CMD_GOTO   = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // fixed command and result field widths
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = 16;
  localparam int POS_W    = 6;

  // per-cycle entry update broadcast to every cell
  typedef struct packed {
    logic insert;      // cell at pos loads the key, cells above take the left neighbor
    logic update;      // cell with the equal line takes the new handle
    logic shift_down;  // cells at or above pos take the right neighbor
  } cell_ctl_t;

endpackage

### rtl/olt_cell.sv
// one table cell: an entry, its local compares and one stage of the scan chain
module olt_cell #(
  parameter int DEPTH       = 32,
  parameter int LINE_BITS   = 16,
  parameter int HANDLE_BITS = 16,
  parameter int INDEX       = 0,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  olt_pkg::cell_ctl_t     ctl,
  input  logic [CNT_W-1:0]       pos,
  input  logic [CNT_W-1:0]       count,
  input  logic [CNT_W-1:0]       cursor,
  input  logic [CNT_W-1:0]       pick_idx,
  input  logic [LINE_BITS-1:0]   key_line,
  input  logic [LINE_BITS-1:0]   key_upper,
  input  logic [HANDLE_BITS-1:0] key_handle,
  // neighbor entries
  input  logic [LINE_BITS-1:0]   left_line,
  input  logic [HANDLE_BITS-1:0] left_handle,
  input  logic [LINE_BITS-1:0]   right_line,
  input  logic [HANDLE_BITS-1:0] right_handle,
  output logic [LINE_BITS-1:0]   line,
  output logic [HANDLE_BITS-1:0] handle,
  // scan chain from the lower neighbor
  input  logic [CNT_W-1:0]       in_lt,
  input  logic [CNT_W-1:0]       in_rng,
  input  logic [CNT_W-1:0]       in_before,
  input  logic                   in_eq,
  input  logic [HANDLE_BITS-1:0] in_eq_handle,
  input  logic                   in_pick,
  input  logic [LINE_BITS-1:0]   in_pick_line,
  input  logic [HANDLE_BITS-1:0] in_pick_handle,
  // scan chain to the upper neighbor
  output logic [CNT_W-1:0]       out_lt,
  output logic [CNT_W-1:0]       out_rng,
  output logic [CNT_W-1:0]       out_before,
  output logic                   out_eq,
  output logic [HANDLE_BITS-1:0] out_eq_handle,
  output logic                   out_pick,
  output logic [LINE_BITS-1:0]   out_pick_line,
  output logic [HANDLE_BITS-1:0] out_pick_handle
);
  import olt_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic valid;
  logic is_lt;
  logic is_eq;
  logic is_rng;
  logic is_before;
  logic is_pick;

  // local compares against the broadcast key
  always_comb begin
    valid     = (IDX < count);
    is_lt     = valid && (line < key_line);
    is_eq     = valid && (line == key_line);
    is_rng    = valid && (line >= key_line) && (line <= key_upper);
    is_before = is_rng && (IDX < cursor);
    is_pick   = valid && (IDX == pick_idx);
  end

  // scan stage: fold this entry into the packet from below
  always_ff @(posedge clk) begin
    out_lt          <= in_lt + CNT_W'(is_lt);
    out_rng         <= in_rng + CNT_W'(is_rng);
    out_before      <= in_before + CNT_W'(is_before);
    out_eq          <= in_eq | is_eq;
    out_eq_handle   <= is_eq ? handle : in_eq_handle;
    out_pick        <= in_pick | is_pick;
    out_pick_line   <= is_pick ? line : in_pick_line;
    out_pick_handle <= is_pick ? handle : in_pick_handle;
  end

  // entry update: insert shift up, handle replace, delete shift down
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (IDX == pos) begin
        line   <= key_line;
        handle <= key_handle;
      end else if (IDX > pos) begin
        line   <= left_line;
        handle <= left_handle;
      end
    end else if (ctl.update) begin
      if (is_eq) begin
        handle <= key_handle;
      end
    end else if (ctl.shift_down) begin
      if (IDX >= pos) begin
        line   <= right_line;
        handle <= right_handle;
      end
    end
  end

endmodule

### rtl/olt_ctrl.sv
// command sequencer: handshakes, scan timing, cursor and count, result register
module olt_ctrl #(
  parameter int DEPTH       = 32,
  parameter int LINE_BITS   = 16,
  parameter int HANDLE_BITS = 16,
  localparam int CNT_W      = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [olt_pkg::CMD_W-1:0]     command,
  input  logic [LINE_BITS-1:0]          line_number,
  input  logic [LINE_BITS-1:0]          line_upper,
  input  logic [HANDLE_BITS-1:0]        statement_handle,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [olt_pkg::STATUS_W-1:0]  status,
  output logic [olt_pkg::OUT_W-1:0]     stmt_handle,
  output logic [olt_pkg::OUT_W-1:0]     stmt_line,
  output logic [olt_pkg::POS_W-1:0]     cursor_pos,
  output logic [olt_pkg::POS_W-1:0]     entry_count,
  // broadcast to the cells
  output olt_pkg::cell_ctl_t            ctl,
  output logic [CNT_W-1:0]              pos,
  output logic [CNT_W-1:0]              count,
  output logic [CNT_W-1:0]              cursor,
  output logic [CNT_W-1:0]              pick_idx,
  output logic [LINE_BITS-1:0]          key_line,
  output logic [LINE_BITS-1:0]          key_upper,
  output logic [HANDLE_BITS-1:0]        key_handle,
  // scan result from the top cell
  input  logic [CNT_W-1:0]              p_lt,
  input  logic [CNT_W-1:0]              p_rng,
  input  logic [CNT_W-1:0]              p_before,
  input  logic                          p_eq,
  input  logic [HANDLE_BITS-1:0]        p_eq_handle,
  input  logic                          p_pick,
  input  logic [LINE_BITS-1:0]          p_pick_line,
  input  logic [HANDLE_BITS-1:0]        p_pick_handle
);
  import olt_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;
  localparam logic [1:0] S_SHIFT = 2'd3;

  logic [1:0]          state;
  logic [IDX_W-1:0]    scan_cnt;
  logic [CNT_W-1:0]    shift_left;
  logic [CNT_W-1:0]    del_pos;
  logic [CMD_W-1:0]    cmd_r;

  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    cursor_next;
  logic [STATUS_W-1:0] status_next;
  logic [HANDLE_BITS-1:0] sel_handle;
  logic [LINE_BITS-1:0]   sel_line;
  logic                go_shift;

  logic [HANDLE_BITS+OUT_W-1:0] handle_ext;
  logic [LINE_BITS+OUT_W-1:0]   line_ext;
  logic [CNT_W+POS_W-1:0]       cursor_ext;
  logic [CNT_W+POS_W-1:0]       count_ext;

  logic cmd_xfer;
  logic rsp_xfer;

  assign cmd_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign cmd_xfer  = cmd_valid && cmd_ready;
  assign rsp_xfer  = rsp_valid && rsp_ready;

  // decide the command from the settled scan result; drive the shift down in the compaction step
  always_comb begin
    ctl         = '0;
    pos         = p_lt;
    count_next  = count;
    cursor_next = cursor;
    status_next = ST_OK;
    sel_handle  = '0;
    sel_line    = '0;
    go_shift    = 1'b0;
    if (state == S_SHIFT) begin
      ctl.shift_down = 1'b1;
      pos            = del_pos;
    end else if (state == S_APPLY) begin
      case (cmd_r)
        CMD_INSERT: begin
          if (p_eq) begin
            ctl.update = 1'b1;
          end else if (count == FULL_CNT) begin
            status_next = ST_FULL;
          end else begin
            ctl.insert = 1'b1;
            count_next = count + ONE;
            if (p_lt <= cursor) begin
              cursor_next = cursor + ONE;
            end
          end
        end
        CMD_DELETE: begin
          count_next  = count - p_rng;
          cursor_next = cursor - p_before;
          go_shift    = (p_rng != '0);
        end
        CMD_RESET: begin
          cursor_next = '0;
        end
        CMD_FETCH, CMD_NEXT: begin
          cursor_next = pick_idx;
          if (p_pick) begin
            sel_handle = p_pick_handle;
            sel_line   = p_pick_line;
          end else begin
            status_next = ST_NONE;
          end
        end
        CMD_GOTO: begin
          if (p_eq) begin
            cursor_next = p_lt;
            sel_handle  = p_eq_handle;
            sel_line    = key_line;
          end else begin
            status_next = ST_NONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // zero extend or truncate to the result field widths
  assign handle_ext = {{OUT_W{1'b0}}, sel_handle};
  assign line_ext   = {{OUT_W{1'b0}}, sel_line};
  assign cursor_ext = {{POS_W{1'b0}}, cursor_next};
  assign count_ext  = {{POS_W{1'b0}}, count_next};

  // sequencer and table state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_cnt   <= '0;
      shift_left <= '0;
      count      <= '0;
      cursor     <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_xfer) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_xfer) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt == SCAN_LAST) begin
            scan_cnt <= '0;
            state    <= S_APPLY;
          end else begin
            scan_cnt <= scan_cnt + IDX_W'(1);
          end
        end
        S_APPLY: begin
          count      <= count_next;
          cursor     <= cursor_next;
          rsp_valid  <= 1'b1;
          shift_left <= p_rng;
          state      <= go_shift ? S_SHIFT : S_IDLE;
        end
        S_SHIFT: begin
          shift_left <= shift_left - ONE;
          if (shift_left == ONE) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command capture and result payload
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      cmd_r      <= command;
      key_line   <= line_number;
      key_upper  <= line_upper;
      key_handle <= statement_handle;
      if (command == CMD_NEXT && cursor < count) begin
        pick_idx <= cursor + ONE;
      end else begin
        pick_idx <= cursor;
      end
    end
    if (state == S_APPLY) begin
      del_pos     <= p_lt;
      status      <= status_next;
      stmt_handle <= handle_ext[OUT_W-1:0];
      stmt_line   <= line_ext[OUT_W-1:0];
      cursor_pos  <= cursor_ext[POS_W-1:0];
      entry_count <= count_ext[POS_W-1:0];
    end
  end

  // cursor never passes the end of the table
  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    (cursor <= count) && (count <= FULL_CNT))
    else $error("cursor or count out of range");

  // the scan runs its full length before the result is applied
  a_scan_length: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_cnt != SCAN_LAST) |=> (state == S_SCAN))
    else $error("scan ended early");

  // a response appears only out of the apply step
  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_APPLY))
    else $error("response without apply");

  // compaction never runs with nothing left to remove
  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (shift_left != '0))
    else $error("compaction with zero removals");

  // no command is taken while the table is being worked on
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer |=> (state == S_SCAN) && !ctl.insert && !ctl.shift_down)
    else $error("command overlap");

endmodule

### rtl/ordered_line_table_with_cursor.sv
// Sorted line table with cursor: a row of entry cells scanned as a systolic chain.
// A command is registered at transfer, its packet is scanned through the DEPTH cell stages, and
// the apply step then registers the response. A new command is taken only in idle, when no
// response waits or it is being taken; before that, a delete that removes entries shifts the
// table down one place per removed entry. The scan time is set by the DEPTH-cell packet chain.
// Reset clears entry count, cursor and handshake state; table entries stay undefined, no clear pass.
module ordered_line_table_with_cursor #(
  parameter int DEPTH       = 32,
  parameter int LINE_BITS   = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [olt_pkg::CMD_W-1:0]     command,
  input  logic [LINE_BITS-1:0]          line_number,
  input  logic [LINE_BITS-1:0]          line_upper,
  input  logic [HANDLE_BITS-1:0]        statement_handle,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [olt_pkg::STATUS_W-1:0]  status,
  output logic [olt_pkg::OUT_W-1:0]     stmt_handle,
  output logic [olt_pkg::OUT_W-1:0]     stmt_line,
  output logic [olt_pkg::POS_W-1:0]     cursor_pos,
  output logic [olt_pkg::POS_W-1:0]     entry_count
);
  import olt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_ctl_t              ctl;
  logic [CNT_W-1:0]       pos;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       cursor;
  logic [CNT_W-1:0]       pick_idx;
  logic [LINE_BITS-1:0]   key_line;
  logic [LINE_BITS-1:0]   key_upper;
  logic [HANDLE_BITS-1:0] key_handle;

  // entries of each cell
  logic [LINE_BITS-1:0]   cell_line   [DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [DEPTH];

  // scan chain links, link 0 is the empty packet
  logic [CNT_W-1:0]       ch_lt          [DEPTH+1];
  logic [CNT_W-1:0]       ch_rng         [DEPTH+1];
  logic [CNT_W-1:0]       ch_before      [DEPTH+1];
  logic                   ch_eq          [DEPTH+1];
  logic [HANDLE_BITS-1:0] ch_eq_handle   [DEPTH+1];
  logic                   ch_pick        [DEPTH+1];
  logic [LINE_BITS-1:0]   ch_pick_line   [DEPTH+1];
  logic [HANDLE_BITS-1:0] ch_pick_handle [DEPTH+1];

  assign ch_lt[0]          = '0;
  assign ch_rng[0]         = '0;
  assign ch_before[0]      = '0;
  assign ch_eq[0]          = 1'b0;
  assign ch_eq_handle[0]   = '0;
  assign ch_pick[0]        = 1'b0;
  assign ch_pick_line[0]   = '0;
  assign ch_pick_handle[0] = '0;

  // sequencer
  olt_ctrl #(
    .DEPTH       (DEPTH),
    .LINE_BITS   (LINE_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .command          (command),
    .line_number      (line_number),
    .line_upper       (line_upper),
    .statement_handle (statement_handle),
    .rsp_valid        (rsp_valid),
    .rsp_ready        (rsp_ready),
    .status           (status),
    .stmt_handle      (stmt_handle),
    .stmt_line        (stmt_line),
    .cursor_pos       (cursor_pos),
    .entry_count      (entry_count),
    .ctl              (ctl),
    .pos              (pos),
    .count            (count),
    .cursor           (cursor),
    .pick_idx         (pick_idx),
    .key_line         (key_line),
    .key_upper        (key_upper),
    .key_handle       (key_handle),
    .p_lt             (ch_lt[DEPTH]),
    .p_rng            (ch_rng[DEPTH]),
    .p_before         (ch_before[DEPTH]),
    .p_eq             (ch_eq[DEPTH]),
    .p_eq_handle      (ch_eq_handle[DEPTH]),
    .p_pick           (ch_pick[DEPTH]),
    .p_pick_line      (ch_pick_line[DEPTH]),
    .p_pick_handle    (ch_pick_handle[DEPTH])
  );

  // row of cells, entry i in cell i
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? 0 : i - 1;
    localparam int RIGHT = (i == DEPTH - 1) ? DEPTH - 1 : i + 1;

    olt_cell #(
      .DEPTH       (DEPTH),
      .LINE_BITS   (LINE_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .INDEX       (i)
    ) u_cell (
      .clk             (clk),
      .ctl             (ctl),
      .pos             (pos),
      .count           (count),
      .cursor          (cursor),
      .pick_idx        (pick_idx),
      .key_line        (key_line),
      .key_upper       (key_upper),
      .key_handle      (key_handle),
      .left_line       (cell_line[LEFT]),
      .left_handle     (cell_handle[LEFT]),
      .right_line      (cell_line[RIGHT]),
      .right_handle    (cell_handle[RIGHT]),
      .line            (cell_line[i]),
      .handle          (cell_handle[i]),
      .in_lt           (ch_lt[i]),
      .in_rng          (ch_rng[i]),
      .in_before       (ch_before[i]),
      .in_eq           (ch_eq[i]),
      .in_eq_handle    (ch_eq_handle[i]),
      .in_pick         (ch_pick[i]),
      .in_pick_line    (ch_pick_line[i]),
      .in_pick_handle  (ch_pick_handle[i]),
      .out_lt          (ch_lt[i+1]),
      .out_rng         (ch_rng[i+1]),
      .out_before      (ch_before[i+1]),
      .out_eq          (ch_eq[i+1]),
      .out_eq_handle   (ch_eq_handle[i+1]),
      .out_pick        (ch_pick[i+1]),
      .out_pick_line   (ch_pick_line[i+1]),
      .out_pick_handle (ch_pick_handle[i+1])
    );
  end

endmodule
